>>> sv/mec_pkg.sv
package mec_pkg;

    // input point and internal iterate widths
    localparam int C_W       = 32;
    localparam int Z_W       = 64;
    localparam int HALF_W    = 32;
    localparam int PROD_W    = 128;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 41;
    localparam int MAXIT_W    = 16;
    localparam int MULT_W     = 32;
    localparam int ESC_W      = 41;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MULT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_SQ  = 2'd2;

    localparam logic [MAXIT_W-1:0] MAX_ITER_RST   = 16'd512;
    localparam logic [MULT_W-1:0]  COLOR_MULT_RST = 32'hFFF0_F6A8;
    localparam logic [ESC_W-1:0]   ESCAPE_SQ_RST  = 41'd1000000000000;

    // result fields
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;

endpackage

>>> sv/mandelbrot_escape_color_unit.sv
// Escape-time coloring of one point of the complex plane.
// Usage: drive i_c_real / i_c_imag (signed Q4.28) and pulse start while busy
// is low; that edge accepts the transaction. busy stays high until the
// result has been shown. Configuration (iteration limit, color multiplier,
// squared escape bound) is written through i_cfg_we / i_cfg_idx / i_cfg_data
// while busy is low; unknown indexes are dropped.
// Each iteration of z = z*z + c runs on one shared 32x32 multiplier: the
// three 64x64 magnitude products take 12 partial products and a final
// accumulation step, then the check, two update states and a magnitude
// state. The exact squares of each new z are reused for its escape test on
// the next pass. The color word then needs one multiply, a load state and
// a restoring divider over the 32-bit quotient (skipped when the limit is
// zero). One point is in flight at a time; the result is held on the
// outputs for exactly one cycle with o_valid high; the receiver cannot
// stall it. Reset returns to idle and restores the default configuration.
module mandelbrot_escape_color_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [mec_pkg::C_W-1:0]     i_c_real,
    input  logic signed [mec_pkg::C_W-1:0]     i_c_imag,
    input  logic                               i_cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mec_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_valid,
    output logic [mec_pkg::COUNT_W-1:0]        o_escape_count,
    output logic [mec_pkg::BYTE_W-1:0]         o_red,
    output logic [mec_pkg::BYTE_W-1:0]         o_green,
    output logic [mec_pkg::BYTE_W-1:0]         o_blue
);
    import mec_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MUL   = 10'b00_0000_0010,
        S_CHECK = 10'b00_0000_0100,
        S_UPD1  = 10'b00_0000_1000,
        S_UPD2  = 10'b00_0001_0000,
        S_MAG   = 10'b00_0010_0000,
        S_CMUL  = 10'b00_0100_0000,
        S_DLOAD = 10'b00_1000_0000,
        S_DIV   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    localparam logic [3:0] LAST_STEP = 4'd12;
    localparam logic [4:0] LAST_DIV  = 5'd31;

    function automatic logic signed [Z_W-1:0] sat_add(
        input logic signed [Z_W-1:0] a,
        input logic signed [Z_W-1:0] b
    );
        logic [Z_W:0] s;
        s = {a[Z_W-1], a} + {b[Z_W-1], b};
        if (s[Z_W] != s[Z_W-1]) begin
            sat_add = s[Z_W] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
        end else begin
            sat_add = s[Z_W-1:0];
        end
    endfunction

    // saturate a shifted magnitude product and apply its sign
    function automatic logic signed [Z_W-1:0] sat_mag(
        input logic [88:0] m,
        input logic        neg
    );
        logic [88:0] lim;
        lim = neg ? (89'd1 << (Z_W-1)) : ((89'd1 << (Z_W-1)) - 89'd1);
        if (m > lim) begin
            sat_mag = neg ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
        end else begin
            sat_mag = neg ? -m[Z_W-1:0] : m[Z_W-1:0];
        end
    endfunction

    t_state r_state;

    logic [MAXIT_W-1:0]      r_max;
    logic [MULT_W-1:0]       r_mult;
    logic [ESC_W-1:0]        r_esc;

    logic signed [Z_W-1:0]   r_cr, r_ci, r_zr, r_zi;
    logic signed [Z_W-1:0]   r_rr, r_ii, r_ri, r_t;
    logic [Z_W-1:0]          r_mr, r_mi;
    logic                    r_ri_neg;
    logic [PROD_W-1:0]       r_acc_rr, r_acc_ii, r_acc_ri;

    logic [3:0]              r_step;
    logic [2*HALF_W-1:0]     r_pp;
    logic                    r_pp_vld;
    logic                    r_pp_first;
    logic [1:0]              r_pp_sel;
    logic [1:0]              r_pp_sh;

    logic [MAXIT_W-1:0]      r_iter;
    logic [COUNT_W-1:0]      r_count;
    logic [WORD_W-1:0]       r_quo;
    logic [MAXIT_W-1:0]      r_rem;
    logic [4:0]              r_dcnt;

    // shared multiplier operand selection
    logic [Z_W-1:0]          opa_full, opb_full;
    logic [HALF_W-1:0]       mul_a, mul_b;
    logic [2*HALF_W-1:0]     mul_p;

    always_comb begin
        opa_full = (r_step[3:2] == 2'd1) ? r_mi : r_mr;
        opb_full = (r_step[3:2] == 2'd0) ? r_mr : r_mi;
        if (r_state == S_CMUL) begin
            mul_a = r_mult;
            mul_b = {{(HALF_W-COUNT_W){1'b0}}, r_count};
        end else begin
            mul_a = r_step[1] ? opa_full[Z_W-1:HALF_W] : opa_full[HALF_W-1:0];
            mul_b = r_step[0] ? opb_full[Z_W-1:HALF_W] : opb_full[HALF_W-1:0];
        end
        mul_p = mul_a * mul_b;
    end

    // partial product accumulation
    logic [PROD_W-1:0] acc_cur, addend, n_acc;

    always_comb begin
        case (r_pp_sel)
            2'd0:    acc_cur = r_acc_rr;
            2'd1:    acc_cur = r_acc_ii;
            default: acc_cur = r_acc_ri;
        endcase
        case (r_pp_sh)
            2'd0:    addend = {{(PROD_W-2*HALF_W){1'b0}}, r_pp};
            2'd1:    addend = {{(PROD_W-3*HALF_W){1'b0}}, r_pp, {HALF_W{1'b0}}};
            default: addend = {r_pp, {(2*HALF_W){1'b0}}};
        endcase
        n_acc = r_pp_first ? addend : acc_cur + addend;
    end

    // escape test on the exact squares of the current z
    logic [PROD_W-1:0] mag_sq, bound;
    logic              escaped;

    assign mag_sq  = r_acc_rr + r_acc_ii;
    assign bound   = {{(PROD_W-ESC_W-80){1'b0}}, r_esc, 80'b0};
    assign escaped = mag_sq > bound;

    // restoring divider step
    logic [MAXIT_W:0] rem_sh;
    logic             div_ge;
    logic [MAXIT_W:0] rem_sub;

    assign rem_sh  = {r_rem, r_quo[WORD_W-1]};
    assign div_ge  = rem_sh >= {1'b0, r_max};
    assign rem_sub = rem_sh - {1'b0, r_max};

    logic signed [Z_W-1:0] n_zr;
    assign n_zr = sat_add(r_t, r_cr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_max    <= MAX_ITER_RST;
            r_mult   <= COLOR_MULT_RST;
            r_esc    <= ESCAPE_SQ_RST;
            r_pp_vld <= 1'b0;
            r_step   <= '0;
            r_iter   <= '0;
            r_dcnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX_ITER:   r_max  <= i_cfg_data[MAXIT_W-1:0];
                    REG_COLOR_MULT: r_mult <= i_cfg_data[MULT_W-1:0];
                    REG_ESCAPE_SQ:  r_esc  <= i_cfg_data[ESC_W-1:0];
                    default: ;
                endcase
            end

            if (r_pp_vld) begin
                case (r_pp_sel)
                    2'd0:    r_acc_rr <= n_acc;
                    2'd1:    r_acc_ii <= n_acc;
                    default: r_acc_ri <= n_acc;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cr     <= {{20{i_c_real[C_W-1]}}, i_c_real, 12'b0};
                        r_ci     <= {{20{i_c_imag[C_W-1]}}, i_c_imag, 12'b0};
                        r_mr     <= '0;
                        r_mi     <= '0;
                        r_ri_neg <= 1'b0;
                        r_iter   <= '0;
                        r_step   <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_step == LAST_STEP) begin
                        r_pp_vld <= 1'b0;
                        r_state  <= S_CHECK;
                    end else begin
                        r_pp       <= mul_p;
                        r_pp_vld   <= 1'b1;
                        r_pp_first <= (r_step[1:0] == 2'd0);
                        r_pp_sel   <= r_step[3:2];
                        r_pp_sh    <= {1'b0, r_step[1]} + {1'b0, r_step[0]};
                        r_step     <= r_step + 4'd1;
                    end
                end
                S_CHECK: begin
                    r_rr <= sat_mag({1'b0, r_acc_rr[PROD_W-1:40]}, 1'b0);
                    r_ii <= sat_mag({1'b0, r_acc_ii[PROD_W-1:40]}, 1'b0);
                    r_ri <= sat_mag(r_acc_ri[PROD_W-1:39], r_ri_neg);
                    if (r_iter != '0 && escaped) begin
                        r_count <= r_iter - 16'd1;
                        r_state <= S_CMUL;
                    end else if (r_iter == r_max) begin
                        r_count <= '0;
                        r_state <= S_CMUL;
                    end else begin
                        r_state <= S_UPD1;
                    end
                end
                S_UPD1: begin
                    r_t     <= sat_add(r_rr, -r_ii);
                    r_zi    <= sat_add(r_ri, r_ci);
                    r_iter  <= r_iter + 16'd1;
                    r_state <= S_UPD2;
                end
                S_UPD2: begin
                    r_zr    <= n_zr;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_mr     <= r_zr[Z_W-1] ? -r_zr : r_zr;
                    r_mi     <= r_zi[Z_W-1] ? -r_zi : r_zi;
                    r_ri_neg <= r_zr[Z_W-1] ^ r_zi[Z_W-1];
                    r_step   <= '0;
                    r_state  <= S_MUL;
                end
                S_CMUL: begin
                    r_pp    <= mul_p;
                    r_state <= S_DLOAD;
                end
                S_DLOAD: begin
                    r_rem  <= '0;
                    r_dcnt <= '0;
                    if (r_max == '0) begin
                        // no division: color word is zero
                        r_quo   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_quo   <= {r_pp[WORD_W-9:0], 8'b0};
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo  <= {r_quo[WORD_W-2:0], div_ge};
                    r_rem  <= div_ge ? rem_sub[MAXIT_W-1:0] : rem_sh[MAXIT_W-1:0];
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == LAST_DIV) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_escape_count = r_count;
    assign o_red          = r_quo[23:16];
    assign o_green        = r_quo[15:8];
    assign o_blue         = r_quo[7:0];

endmodule
